// ===== design/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Types and codes shared by the execute stage modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_WRITE   = 3'd1,
    OUT_LOAD    = 3'd2,
    OUT_STORE   = 3'd3,
    OUT_HALT    = 3'd4,
    OUT_ILLEGAL = 3'd5
  } outcome_t;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_NORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_HALT  = 6'h3f;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic [5:0]  command;
    logic [5:0]  function_code;
    logic [31:0] operand_s;
    logic [31:0] operand_t;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [4:0]  dest_reg;
    logic [31:0] link_value;
  } instr_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [4:0]  write_index;
    logic [31:0] result_value;
    logic [31:0] store_data;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [31:0] high;
    logic [31:0] low;
  } product_t;

  typedef struct packed {
    logic     write;
    product_t value;
  } mult_ctl_t;

endpackage

// ===== design/mse_alu.sv =====
// ----------------------------------------------------------------------------
// mse_alu
// Decode and arithmetic for one instruction; also forms the multiply product.
// ----------------------------------------------------------------------------
module mse_alu
  import mse_pkg::*;
(
  input  instr_t    instr,
  input  product_t  product,
  output result_t   result,
  output mult_ctl_t mult
);

  logic [31:0] s;
  logic [31:0] t;
  logic [31:0] imm_ext;
  logic [31:0] imm_zext;
  logic [31:0] sum_rt;
  logic [31:0] diff_rt;
  logic [31:0] sum_imm;
  logic        ovf_add;
  logic        ovf_sub;
  logic        ovf_imm;
  logic        signed_mul;
  logic [32:0] s_x;
  logic [32:0] t_x;
  logic signed [63:0] prod;

  assign s        = instr.operand_s;
  assign t        = instr.operand_t;
  assign imm_ext  = {{16{instr.immediate[15]}}, instr.immediate};
  assign imm_zext = {16'h0000, instr.immediate};
  assign sum_rt   = s + t;
  assign diff_rt  = s - t;
  assign sum_imm  = s + imm_ext;
  assign ovf_add  = (s[31] == t[31]) && (sum_rt[31] != s[31]);
  assign ovf_sub  = (s[31] != t[31]) && (diff_rt[31] != s[31]);
  assign ovf_imm  = (s[31] == imm_ext[31]) && (sum_imm[31] != s[31]);

  assign signed_mul = (instr.function_code == FN_MULT);
  assign s_x  = {signed_mul & s[31], s};
  assign t_x  = {signed_mul & t[31], t};
  assign prod = $signed(s_x) * $signed(t_x);

  assign mult.write      = (instr.command == OP_RTYPE) &&
                           ((instr.function_code == FN_MULT) ||
                            (instr.function_code == FN_MULTU));
  assign mult.value.high = prod[63:32];
  assign mult.value.low  = prod[31:0];

  always_comb begin
    result = '0;
    result.outcome = OUT_NONE;
    case (instr.command)
      OP_RTYPE: begin
        result.outcome     = OUT_WRITE;
        result.write_index = instr.dest_reg;
        case (instr.function_code)
          FN_ADD: begin
            result.result_value = sum_rt;
            result.overflow     = ovf_add;
          end
          FN_ADDU: result.result_value = sum_rt;
          FN_SUB: begin
            result.result_value = diff_rt;
            result.overflow     = ovf_sub;
          end
          FN_AND:  result.result_value = s & t;
          FN_OR:   result.result_value = s | t;
          FN_XOR:  result.result_value = s ^ t;
          FN_NOR:  result.result_value = ~(s | t);
          FN_NAND: result.result_value = ~(s & t);
          FN_SLT:  result.result_value = {31'd0, $signed(s) < $signed(t)};
          FN_SLL:  result.result_value = t << instr.shift_amount;
          FN_SRL:  result.result_value = t >> instr.shift_amount;
          FN_SRA:  result.result_value = $unsigned($signed(t) >>> instr.shift_amount);
          FN_MFHI: result.result_value = product.high;
          FN_MFLO: result.result_value = product.low;
          FN_JR, FN_MULT, FN_MULTU: result.outcome = OUT_NONE;
          default: result.outcome = OUT_ILLEGAL;
        endcase
      end
      OP_J, OP_BEQ, OP_BNE, OP_BGTZ: result.outcome = OUT_NONE;
      OP_JAL: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = LINK_REG;
        result.result_value = instr.link_value;
      end
      OP_HALT: result.outcome = OUT_HALT;
      OP_ADDI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = sum_imm;
        result.overflow     = ovf_imm;
      end
      OP_ADDIU: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = sum_imm;
      end
      OP_ANDI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = s & imm_zext;
      end
      OP_ORI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = s | imm_zext;
      end
      OP_NORI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = ~(s | imm_zext);
      end
      OP_SLTI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = {31'd0, $signed(s) < $signed(imm_ext)};
      end
      OP_LUI: begin
        result.outcome      = OUT_WRITE;
        result.write_index  = instr.dest_reg;
        result.result_value = {instr.immediate, 16'h0000};
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        result.outcome      = OUT_LOAD;
        result.write_index  = instr.dest_reg;
        result.result_value = sum_imm;
        result.overflow     = ovf_imm;
      end
      OP_SB, OP_SH, OP_SW: begin
        result.outcome      = OUT_STORE;
        result.result_value = sum_imm;
        result.store_data   = t;
        result.overflow     = ovf_imm;
      end
      default: result.outcome = OUT_ILLEGAL;
    endcase

    // writes to register zero are dropped; overflow is still reported
    if (result.outcome == OUT_WRITE && result.write_index == 5'd0) begin
      result.outcome      = OUT_NONE;
      result.result_value = '0;
    end
  end

endmodule

// ===== design/mse_hilo.sv =====
// ----------------------------------------------------------------------------
// mse_hilo
// Hi/lo product register written by mult and multu.
// ----------------------------------------------------------------------------
module mse_hilo
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mult_ctl_t update,
  output product_t  product
);

  always_ff @(posedge clk) begin
    if (rst) begin
      product <= '0;
    end else if (update.write) begin
      product <= update.value;
    end
  end

endmodule

// ===== design/mips_subset_execute_alu.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_alu
// Execute stage of a small MIPS-like core.
//
// Slave channel s_*: one decoded instruction per beat, operands already
// forwarded; opcode and function code ride on s_tuser.
// Master channel m_*: one result beat per instruction, outcome on m_tuser.
// An accepted beat is held in an input register, evaluated in one pass and
// captured in the result register, from which m_tvalid is driven; throughput
// one instruction per cycle while the receiver does not stall.
// mult/multu write hi/lo as the instruction moves into the result register,
// so an mfhi/mflo right behind it reads the new product.
// Reset clears both stages and hi/lo; no beat is offered until the first
// instruction is taken.
// When the receiver stalls, the result holds on m_*; one more instruction
// is taken into the input register, then s_tready drops until m_tready.
// ----------------------------------------------------------------------------
module mips_subset_execute_alu
  import mse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] operand_s, [63:32] operand_t, [79:64] immediate,
  // [84:80] shift_amount, [89:85] dest_reg, [121:90] link_value, rest zero
  input  logic [127:0] s_tdata,
  // [5:0] command, [11:6] function_code
  input  logic [11:0]  s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [4:0] write_index, [36:5] result_value, [68:37] store_data,
  // [69] overflow, rest zero
  output logic [71:0]  m_tdata,
  // [2:0] outcome
  output logic [2:0]   m_tuser
);

  instr_t    instr_in;
  instr_t    stage;
  logic      stage_valid;
  result_t   result;
  result_t   out_result;
  logic      out_valid;
  logic      advance;
  product_t  product;
  mult_ctl_t mult;
  mult_ctl_t hilo_update;

  always_comb begin
    instr_in.command       = s_tuser[5:0];
    instr_in.function_code = s_tuser[11:6];
    instr_in.operand_s     = s_tdata[31:0];
    instr_in.operand_t     = s_tdata[63:32];
    instr_in.immediate     = s_tdata[79:64];
    instr_in.shift_amount  = s_tdata[84:80];
    instr_in.dest_reg      = s_tdata[89:85];
    instr_in.link_value    = s_tdata[121:90];
  end

  assign advance  = stage_valid && (!out_valid || m_tready);
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage <= instr_in;
    end
  end

  mse_alu u_alu (
    .instr   (stage),
    .product (product),
    .result  (result),
    .mult    (mult)
  );

  assign hilo_update.write = mult.write && advance;
  assign hilo_update.value = mult.value;

  mse_hilo u_hilo (
    .clk     (clk),
    .rst     (rst),
    .update  (hilo_update),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.outcome;
  assign m_tdata  = {2'b00, out_result.overflow, out_result.store_data,
                     out_result.result_value, out_result.write_index};

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !stage_valid))
    else $error("pipeline not empty after reset");

  a_hilo_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(product))
    else $error("hi/lo changed without an instruction moving");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are held");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stage_valid)
    else $error("accepted beat lost from input register");

  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("evaluated instruction not offered");

endmodule

// ===== test/mips_subset_execute_alu_checker.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_alu_checker
// Watches both streams of the execute stage. It predicts each accepted
// instruction with its own copy of hi/lo, queues the predicted result and
// compares every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mips_subset_execute_alu_checker
  import mse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [11:0]  s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic [2:0]   m_tuser,
  output int           mismatches,
  output int           outstanding,
  output int           results_checked,
  output int           overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] prod_hi;
  logic [31:0] prod_lo;
  result_t     pending_results[$];

  assign outstanding = pending_results.size();

  function automatic logic add_overflow(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] sum;
    sum = a + b;
    return (a[31] == b[31]) && (sum[31] != a[31]);
  endfunction

  // updates prod_hi/prod_lo on mult/multu
  function automatic result_t execute_instr(input instr_t ins);
    result_t            r;
    logic [31:0]        s;
    logic [31:0]        t;
    logic [31:0]        imm_sx;
    logic [31:0]        imm_zx;
    logic signed [63:0] prod_s;
    logic [63:0]        prod_u;
    s = ins.operand_s;
    t = ins.operand_t;
    imm_sx = {{16{ins.immediate[15]}}, ins.immediate};
    imm_zx = {16'h0000, ins.immediate};
    r = '0;
    r.outcome = OUT_NONE;
    if (ins.command == OP_RTYPE) begin
      r.outcome = OUT_WRITE;
      r.write_index = ins.dest_reg;
      case (ins.function_code)
        FN_ADD: begin
          r.result_value = s + t;
          r.overflow = add_overflow(s, t);
        end
        FN_ADDU: r.result_value = s + t;
        FN_SUB: begin
          r.result_value = s - t;
          r.overflow = (s[31] != t[31]) && (r.result_value[31] != s[31]);
        end
        FN_AND:  r.result_value = s & t;
        FN_OR:   r.result_value = s | t;
        FN_XOR:  r.result_value = s ^ t;
        FN_NOR:  r.result_value = ~(s | t);
        FN_NAND: r.result_value = ~(s & t);
        FN_SLT:  r.result_value = {31'b0, $signed(s) < $signed(t)};
        FN_SLL:  r.result_value = t << ins.shift_amount;
        FN_SRL:  r.result_value = t >> ins.shift_amount;
        FN_SRA:  r.result_value = $signed(t) >>> ins.shift_amount;
        FN_MFHI: r.result_value = prod_hi;
        FN_MFLO: r.result_value = prod_lo;
        FN_JR:   r.outcome = OUT_NONE;
        FN_MULT: begin
          prod_s = $signed({{32{s[31]}}, s}) * $signed({{32{t[31]}}, t});
          prod_hi = prod_s[63:32];
          prod_lo = prod_s[31:0];
          r.outcome = OUT_NONE;
        end
        FN_MULTU: begin
          prod_u = {32'h0, s} * {32'h0, t};
          prod_hi = prod_u[63:32];
          prod_lo = prod_u[31:0];
          r.outcome = OUT_NONE;
        end
        default: r.outcome = OUT_ILLEGAL;
      endcase
    end else begin
      case (ins.command)
        OP_J, OP_BEQ, OP_BNE, OP_BGTZ: ;
        OP_JAL: begin
          r.outcome = OUT_WRITE;
          r.write_index = LINK_REG;
          r.result_value = ins.link_value;
        end
        OP_HALT: r.outcome = OUT_HALT;
        OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_NORI, OP_SLTI, OP_LUI: begin
          r.outcome = OUT_WRITE;
          r.write_index = ins.dest_reg;
          case (ins.command)
            OP_ADDI: begin
              r.result_value = s + imm_sx;
              r.overflow = add_overflow(s, imm_sx);
            end
            OP_ADDIU: r.result_value = s + imm_sx;
            OP_ANDI:  r.result_value = s & imm_zx;
            OP_ORI:   r.result_value = s | imm_zx;
            OP_NORI:  r.result_value = ~(s | imm_zx);
            OP_SLTI:  r.result_value = {31'b0, $signed(s) < $signed(imm_sx)};
            default:  r.result_value = {ins.immediate, 16'h0000};
          endcase
        end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          r.outcome = OUT_LOAD;
          r.write_index = ins.dest_reg;
          r.result_value = s + imm_sx;
          r.overflow = add_overflow(s, imm_sx);
        end
        OP_SB, OP_SH, OP_SW: begin
          r.outcome = OUT_STORE;
          r.result_value = s + imm_sx;
          r.overflow = add_overflow(s, imm_sx);
          r.store_data = t;
        end
        default: r.outcome = OUT_ILLEGAL;
      endcase
    end
    // register zero is never written; overflow is still reported
    if (r.outcome == OUT_WRITE && r.write_index == 5'd0) begin
      r.outcome = OUT_NONE;
      r.result_value = '0;
    end
    return r;
  endfunction

  task automatic report_error(input string field, input logic [31:0] got,
                              input logic [31:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t: result %0d %s mismatch: got 0x%08h, expected 0x%08h",
               $realtime, results_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    instr_t  ins;
    result_t want;
    if (rst) begin
      prod_hi = '0;
      prod_lo = '0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_error("unexpected beat", {29'b0, m_tuser}, 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.outcome)
            report_error("outcome", {29'b0, m_tuser}, {29'b0, want.outcome});
          if (m_tdata[4:0] != want.write_index)
            report_error("write_index", {27'b0, m_tdata[4:0]}, {27'b0, want.write_index});
          if (m_tdata[36:5] != want.result_value)
            report_error("result_value", m_tdata[36:5], want.result_value);
          if (m_tdata[68:37] != want.store_data)
            report_error("store_data", m_tdata[68:37], want.store_data);
          if (m_tdata[69] != want.overflow)
            report_error("overflow", {31'b0, m_tdata[69]}, {31'b0, want.overflow});
          if (want.overflow)
            overflow_seen++;
        end
        results_checked++;
      end
      if (s_tvalid && s_tready) begin
        ins.command = s_tuser[5:0];
        ins.function_code = s_tuser[11:6];
        ins.operand_s = s_tdata[31:0];
        ins.operand_t = s_tdata[63:32];
        ins.immediate = s_tdata[79:64];
        ins.shift_amount = s_tdata[84:80];
        ins.dest_reg = s_tdata[89:85];
        ins.link_value = s_tdata[121:90];
        pending_results.push_back(execute_instr(ins));
      end
    end
  end

  initial begin
    mismatches = 0;
    results_checked = 0;
    overflow_seen = 0;
  end

endmodule

// ===== test/mips_subset_execute_alu_tb.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_alu_tb
// Drives the execute stage with directed corner instructions and then bursts
// of random instructions against a stalling receiver; the checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module mips_subset_execute_alu_tb;
  import mse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [11:0]  s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;
  logic [2:0]   m_tuser;

  int mismatches;
  int outstanding;
  int results_checked;
  int overflow_seen;
  int instrs_sent;
  int cycle_count;
  int stall_mode;
  int stall_len;

  mips_subset_execute_alu u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mips_subset_execute_alu_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .overflow_seen   (overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mips_subset_execute_alu test failed");
      $finish;
    end
  end

  function automatic instr_t mk(input logic [5:0] cmd, input logic [5:0] fn,
                                input logic [31:0] s, input logic [31:0] t,
                                input logic [15:0] imm, input logic [4:0] sh,
                                input logic [4:0] dst, input logic [31:0] link);
    instr_t ins;
    ins.command = cmd;
    ins.function_code = fn;
    ins.operand_s = s;
    ins.operand_t = t;
    ins.immediate = imm;
    ins.shift_amount = sh;
    ins.dest_reg = dst;
    ins.link_value = link;
    return ins;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'h0000_0001;
      5:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7fff;
      2:       return 16'h8000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_fn(input int idx);
    case (idx)
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_SRA;
      3:       return FN_JR;
      4:       return FN_MFHI;
      5:       return FN_MFLO;
      6:       return FN_MULT;
      7:       return FN_MULTU;
      8:       return FN_ADD;
      9:       return FN_ADDU;
      10:      return FN_SUB;
      11:      return FN_AND;
      12:      return FN_OR;
      13:      return FN_XOR;
      14:      return FN_NOR;
      15:      return FN_NAND;
      default: return FN_SLT;
    endcase
  endfunction

  function automatic logic [5:0] pick_op(input int idx);
    case (idx)
      0:       return OP_J;
      1:       return OP_JAL;
      2:       return OP_BEQ;
      3:       return OP_BNE;
      4:       return OP_BGTZ;
      5:       return OP_ADDI;
      6:       return OP_ADDIU;
      7:       return OP_SLTI;
      8:       return OP_ANDI;
      9:       return OP_ORI;
      10:      return OP_NORI;
      11:      return OP_LUI;
      12:      return OP_LB;
      13:      return OP_LH;
      14:      return OP_LW;
      15:      return OP_LBU;
      16:      return OP_LHU;
      17:      return OP_SB;
      18:      return OP_SH;
      19:      return OP_SW;
      default: return OP_HALT;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int     pick;
    ins = mk(6'($urandom), 6'($urandom), rand_word(), rand_word(), rand_half(),
             5'($urandom), 5'($urandom), $urandom);
    if ($urandom_range(0, 7) == 0)
      ins.dest_reg = 5'd0;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      ins.command = OP_RTYPE;
      ins.function_code = pick_fn($urandom_range(0, 16));
    end else if (pick < 93) begin
      ins.command = pick_op($urandom_range(0, 20));
    end else if (pick < 97) begin
      ins.command = OP_RTYPE;
    end
    return ins;
  endfunction

  task automatic send_instr(input instr_t ins);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= {ins.function_code, ins.command};
    s_tdata  <= {6'b0, ins.link_value, ins.dest_reg, ins.shift_amount,
                 ins.immediate, ins.operand_t, ins.operand_s};
    do @(posedge clk); while (!s_tready);
    instrs_sent++;
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver: stretches of free flow, random stalls and long stalls
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall_mode = $urandom_range(0, 3);
      stall_len = $urandom_range(10, 60);
      repeat (stall_len) begin
        @(negedge clk);
        case (stall_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int burst;
    int sent_random;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    instrs_sent = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    send_instr(mk(OP_RTYPE, FN_ADD,   32'h7fffffff, 32'h00000001, 16'h0, 5'd0, 5'd1, 32'h0));
    send_instr(mk(OP_RTYPE, FN_ADD,   32'h80000000, 32'hffffffff, 16'h0, 5'd0, 5'd2, 32'h0));
    send_instr(mk(OP_RTYPE, FN_ADDU,  32'hffffffff, 32'h00000001, 16'h0, 5'd0, 5'd3, 32'h0));
    send_instr(mk(OP_RTYPE, FN_SUB,   32'h80000000, 32'h00000001, 16'h0, 5'd0, 5'd4, 32'h0));
    send_instr(mk(OP_RTYPE, FN_NAND,  32'hffffffff, 32'h0f0f0f0f, 16'h0, 5'd0, 5'd5, 32'h0));
    send_instr(mk(OP_RTYPE, FN_NOR,   32'h00000000, 32'h00000000, 16'h0, 5'd0, 5'd6, 32'h0));
    send_instr(mk(OP_RTYPE, FN_SLT,   32'h80000000, 32'h7fffffff, 16'h0, 5'd0, 5'd7, 32'h0));
    send_instr(mk(OP_RTYPE, FN_SLL,   32'h0, 32'h0, 16'h0, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_RTYPE, FN_SLL,   32'h0, 32'hffffffff, 16'h0, 5'd31, 5'd8, 32'h0));
    send_instr(mk(OP_RTYPE, FN_SRA,   32'h0, 32'h80000000, 16'h0, 5'd31, 5'd9, 32'h0));
    send_instr(mk(OP_RTYPE, FN_MULT,  32'h80000000, 32'hffffffff, 16'h0, 5'd0, 5'd10, 32'h0));
    send_instr(mk(OP_RTYPE, FN_MFHI,  32'h0, 32'h0, 16'h0, 5'd0, 5'd11, 32'h0));
    send_instr(mk(OP_RTYPE, FN_MULTU, 32'hffffffff, 32'hffffffff, 16'h0, 5'd0, 5'd12, 32'h0));
    send_instr(mk(OP_RTYPE, FN_MFLO,  32'h0, 32'h0, 16'h0, 5'd0, 5'd13, 32'h0));
    send_instr(mk(OP_RTYPE, FN_JR,    32'h12345678, 32'h0, 16'h0, 5'd0, 5'd14, 32'h0));
    send_instr(mk(OP_RTYPE, 6'h3f,    32'h1, 32'h2, 16'h0, 5'd0, 5'd15, 32'h0));
    send_instr(mk(OP_J,     6'h0,     32'h1, 32'h2, 16'h1, 5'd0, 5'd16, 32'hdeadbeef));
    send_instr(mk(OP_JAL,   6'h0,     32'h1, 32'h2, 16'h1, 5'd0, 5'd0, 32'hffffffff));
    send_instr(mk(OP_ADDI,  6'h0,     32'h7fffffff, 32'h0, 16'h7fff, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_SLTI,  6'h0,     32'hffffffff, 32'h0, 16'h0000, 5'd0, 5'd17, 32'h0));
    send_instr(mk(OP_NORI,  6'h0,     32'h00000000, 32'h0, 16'hffff, 5'd0, 5'd18, 32'h0));
    send_instr(mk(OP_LUI,   6'h0,     32'h0, 32'h0, 16'h8000, 5'd0, 5'd19, 32'h0));
    send_instr(mk(OP_LW,    6'h0,     32'h80000000, 32'h0, 16'hffff, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_SW,    6'h0,     32'h7fffffff, 32'hcafef00d, 16'h0001, 5'd0, 5'd20, 32'h0));
    send_instr(mk(OP_HALT,  6'h0,     32'h0, 32'h0, 16'h0, 5'd0, 5'd21, 32'h0));
    send_instr(mk(6'h3e,    6'h0,     32'h0, 32'h0, 16'h0, 5'd0, 5'd22, 32'h0));
    drain_results();

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_instr(rand_instr());
        sent_random++;
      end
      if (sent_random > RANDOM_ITEMS / 2 && sent_random - burst <= RANDOM_ITEMS / 2)
        drain_results();
      else if ($urandom_range(0, 3) != 0)
        hold_off($urandom_range(1, 8));
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("sent %0d instructions (directed corners, random R/I-type, illegal codes)",
             instrs_sent);
    $display("checked %0d result beats, %0d with overflow set", results_checked,
             overflow_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mips_subset_execute_alu test passed");
    end else begin
      $display("mips_subset_execute_alu test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mse_pkg.sv
design/mse_alu.sv
design/mse_hilo.sv
design/mips_subset_execute_alu.sv
test/mips_subset_execute_alu_checker.sv
test/mips_subset_execute_alu_tb.sv
